/* rtl/rse_pkg.sv */
// ----------------------------------------------------------------------------
// rse_pkg
// Shared constants and types for the RPN stack evaluator: widths, stack
// depth, item kinds, status codes and the sequencer states.
// ----------------------------------------------------------------------------
package rse_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int STACK_AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int STACK_CW    = $clog2(STACK_DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int NUM_W       = 31;
    localparam int OP_W        = 3;
    localparam int STATUS_W    = 3;
    localparam int DIV_CW      = $clog2(DATA_W);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_END  = 3'd5,
        OP_BAD  = 3'd6
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FEW      = 3'd1,
        ST_DIVZ     = 3'd2,
        ST_BADTOK   = 3'd3,
        ST_LEFTOVER = 3'd4,
        ST_OVERFLOW = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

endpackage

/* rtl/rse_div.sv */
// ----------------------------------------------------------------------------
// rse_div
// Bit-serial signed divider, truncating toward zero. One quotient bit per
// cycle over the operand magnitudes; done pulses for one cycle when the
// quotient is ready. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module rse_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rse_pkg::DATA_W-1:0] i_dividend,
    input  logic [rse_pkg::DATA_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rse_pkg::DATA_W-1:0] o_quot
);
    import rse_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_neg;
    logic [DIV_CW-1:0] r_cnt;
    logic [DATA_W-1:0] r_q;
    logic [DATA_W-1:0] r_rem;
    logic [DATA_W-1:0] r_dvs;

    logic [DATA_W-1:0] w_mag_n;
    logic [DATA_W-1:0] w_mag_d;
    logic [DATA_W:0]   w_shift;
    logic [DATA_W:0]   w_diff;
    logic              w_fit;

    assign w_mag_n = i_dividend[DATA_W-1] ? (~i_dividend + DATA_W'(1)) : i_dividend;
    assign w_mag_d = i_divisor[DATA_W-1]  ? (~i_divisor + DATA_W'(1))  : i_divisor;
    assign w_shift = {r_rem, r_q[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_fit   = ~w_diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CW'(DATA_W - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= w_mag_n;
            r_dvs <= w_mag_d;
            r_rem <= '0;
            r_cnt <= '0;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DATA_W-1:0] : w_shift[DATA_W-1:0];
            r_q   <= {r_q[DATA_W-2:0], w_fit};
            r_cnt <= r_cnt + DIV_CW'(1);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (~r_q + DATA_W'(1)) : r_q;

endmodule

/* rtl/rpn_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Evaluates pre-tokenized reverse Polish items on a 32-bit signed operand
// stack held in a memory, with a cached top of stack and a bit-serial divider.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+------------------------------
//   in      | input     | i_in_valid / o_in_stall | i_op, i_number
//   out     | output    | o_out_valid / i_out_stall | o_status, o_top_value, o_done_res
//
// From accept to result register: push, end, invalid, ignored and too few
// operands pass decode and output; divide by zero decode, execute, output;
// add, sub, mul decode, execute, write-back, output; div also waits on the
// bit-serial divider (one quotient bit per cycle) before write-back. Input
// is stalled until the cycle after the result is loaded; a new beat is
// taken while that result still waits downstream. Synchronous reset clears
// the stack count and latched error; the stack memory itself is not cleared.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rse_pkg::OP_W-1:0]            i_op,
    input  logic [rse_pkg::NUM_W-1:0]           i_number,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [rse_pkg::STATUS_W-1:0]        o_status,
    output logic signed [rse_pkg::DATA_W-1:0]   o_top_value,
    output logic                                o_done_res
);
    import rse_pkg::*;

    logic [DATA_W-1:0] r_mem [STACK_DEPTH];

    t_state              r_state,   n_state;
    t_op                 r_op,      n_op;
    logic [NUM_W-1:0]    r_num,     n_num;
    logic [STACK_CW-1:0] r_count,   n_count;
    t_status             r_err,     n_err;
    logic [DATA_W-1:0]   r_top,     n_top;
    logic [DATA_W-1:0]   r_res,     n_res;
    t_status             r_end_st,  n_end_st;
    logic [DATA_W-1:0]   r_end_val, n_end_val;
    logic [DATA_W-1:0]   r_a;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [DATA_W-1:0]   r_out_top;
    logic                r_out_done;

    logic                w_we;
    logic [STACK_AW-1:0] w_waddr;
    logic [DATA_W-1:0]   w_wdata;
    logic [STACK_CW-1:0] w_below;
    logic [2*DATA_W-1:0] w_prod;
    logic                w_div_start;
    logic                w_div_done;
    logic [DATA_W-1:0]   w_quot;
    logic                w_out_load;
    logic                w_out_free;

    rse_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_a),
        .i_divisor  (r_top),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_below    = r_count - STACK_CW'(2);
    assign w_prod     = r_a * r_top;
    assign w_out_free = ~r_out_valid | ~i_out_stall;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_a <= r_mem[w_below[STACK_AW-1:0]];
    end

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_num       = r_num;
        n_count     = r_count;
        n_err       = r_err;
        n_top       = r_top;
        n_res       = r_res;
        n_end_st    = r_end_st;
        n_end_val   = r_end_val;
        w_we        = 1'b0;
        w_waddr     = w_below[STACK_AW-1:0];
        w_wdata     = r_res;
        w_div_start = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = t_op'(i_op);
                    n_num   = i_number;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_OUT;
                if (r_op == OP_END) begin
                    n_end_st  = r_err;
                    n_end_val = '0;
                    if (r_err == ST_OK) begin
                        if (r_count != STACK_CW'(1)) begin
                            n_end_st = ST_LEFTOVER;
                        end else begin
                            n_end_val = r_top;
                        end
                    end
                    n_count = '0;
                    n_err   = ST_OK;
                    n_top   = '0;
                end else if (r_err == ST_OK) begin
                    case (r_op)
                        OP_PUSH: begin
                            if (r_count >= STACK_CW'(STACK_DEPTH)) begin
                                n_err = ST_OVERFLOW;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = r_count[STACK_AW-1:0];
                                w_wdata = {1'b0, r_num};
                                n_count = r_count + STACK_CW'(1);
                                n_top   = {1'b0, r_num};
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (r_count < STACK_CW'(2)) begin
                                n_err = ST_FEW;
                            end else begin
                                n_state = S_EXEC;
                            end
                        end
                        default: begin
                            n_err = ST_BADTOK;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                n_state = S_WB;
                case (r_op)
                    OP_ADD: n_res = r_a + r_top;
                    OP_SUB: n_res = r_a - r_top;
                    OP_MUL: n_res = w_prod[DATA_W-1:0];
                    default: begin
                        if (r_top == '0) begin
                            n_err   = ST_DIVZ;
                            n_state = S_OUT;
                        end else begin
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_res   = w_quot;
                    n_state = S_WB;
                end
            end
            S_WB: begin
                w_we    = 1'b1;
                w_waddr = w_below[STACK_AW-1:0];
                w_wdata = r_res;
                n_count = r_count - STACK_CW'(1);
                n_top   = r_res;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_err   <= ST_OK;
            r_top   <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_err   <= n_err;
            r_top   <= n_top;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_num     <= n_num;
        r_res     <= n_res;
        r_end_st  <= n_end_st;
        r_end_val <= n_end_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_op == OP_END) begin
                r_out_status <= r_end_st;
                r_out_top    <= r_end_val;
                r_out_done   <= 1'b1;
            end else begin
                r_out_status <= r_err;
                r_out_top    <= r_top;
                r_out_done   <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_top_value = $signed(r_out_top);
    assign o_done_res  = r_out_done;

endmodule

/* tb/rse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rse_checker
// Watches both channels of the RPN stack evaluator. Every accepted input beat
// is run through a local model of the operand stack and latched error; the
// expected result is queued and compared field by field with the next
// accepted output beat. Failures, outstanding results and run totals are
// reported to the testbench top.
// ----------------------------------------------------------------------------
module rse_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic [rse_pkg::OP_W-1:0]            i_op,
    input  logic [rse_pkg::NUM_W-1:0]           i_number,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic [rse_pkg::STATUS_W-1:0]        i_status,
    input  logic signed [rse_pkg::DATA_W-1:0]   i_top_value,
    input  logic                                i_done_res,
    output int                                  o_fail_cnt,
    output int                                  o_pending,
    output int                                  o_beats_in,
    output int                                  o_ok_exprs,
    output int                                  o_err_exprs
);
    import rse_pkg::*;

    typedef struct packed {
        t_status                   status;
        logic signed [DATA_W-1:0]  top;
        logic                      done;
    } t_result;

    logic [DATA_W-1:0] stk [STACK_DEPTH];
    int                depth;
    t_status           err;
    t_result           exp_results [$];

    int fail_cnt    = 0;
    int pending_cnt = 0;
    int beats_in    = 0;
    int ok_exprs    = 0;
    int err_exprs   = 0;

    assign o_fail_cnt  = fail_cnt;
    assign o_pending   = pending_cnt;
    assign o_beats_in  = beats_in;
    assign o_ok_exprs  = ok_exprs;
    assign o_err_exprs = err_exprs;

    function automatic t_result eval_token(input logic [OP_W-1:0] op,
                                           input logic [NUM_W-1:0] num);
        t_result           r;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic [DATA_W-1:0] ma;
        logic [DATA_W-1:0] mb;
        logic [DATA_W-1:0] q;
        r = '0;
        if (op == OP_END) begin
            r.done   = 1'b1;
            r.status = err;
            if (err == ST_OK) begin
                if (depth != 1) begin
                    r.status = ST_LEFTOVER;
                end else begin
                    r.top = stk[0];
                end
            end
            depth = 0;
            err   = ST_OK;
            return r;
        end
        if (err == ST_OK) begin
            case (op)
                OP_PUSH: begin
                    if (depth >= STACK_DEPTH) begin
                        err = ST_OVERFLOW;
                    end else begin
                        stk[depth] = {1'b0, num};
                        depth++;
                    end
                end
                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                    if (depth < 2) begin
                        err = ST_FEW;
                    end else begin
                        b = stk[depth-1];
                        a = stk[depth-2];
                        q = '0;
                        case (op)
                            OP_ADD: q = a + b;
                            OP_SUB: q = a - b;
                            OP_MUL: q = a * b;
                            default: begin
                                if (b == '0) begin
                                    err = ST_DIVZ;
                                end else begin
                                    // truncate toward zero on magnitudes
                                    ma = a[DATA_W-1] ? -a : a;
                                    mb = b[DATA_W-1] ? -b : b;
                                    q  = ma / mb;
                                    if (a[DATA_W-1] ^ b[DATA_W-1]) begin
                                        q = -q;
                                    end
                                end
                            end
                        endcase
                        if (err == ST_OK) begin
                            stk[depth-2] = q;
                            depth--;
                        end
                    end
                end
                default: err = ST_BADTOK;
            endcase
        end
        r.status = err;
        r.top    = (depth == 0) ? '0 : stk[depth-1];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            depth = 0;
            err   = ST_OK;
            exp_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (exp_results.size() == 0) begin
                    fail_cnt++;
                    $display("%0t: unexpected result beat: status %0d top %0d done %0d",
                             $time, i_status, i_top_value, i_done_res);
                end else begin
                    want = exp_results.pop_front();
                    if (i_status !== want.status || i_top_value !== want.top ||
                        i_done_res !== want.done) begin
                        fail_cnt++;
                        $display("%0t: mismatch: expected status %0d top %0d done %0d,",
                                 $time, want.status, want.top, want.done);
                        $display("    got status %0d top %0d done %0d",
                                 i_status, i_top_value, i_done_res);
                    end
                    if (want.done) begin
                        if (want.status == ST_OK) begin
                            ok_exprs++;
                        end else begin
                            err_exprs++;
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                exp_results.push_back(eval_token(i_op, i_number));
                beats_in++;
            end
        end
        pending_cnt = exp_results.size();
    end

endmodule

/* tb/rpn_stack_evaluator_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_evaluator_tb
// Stimulus and verdict for the RPN stack evaluator. A directed opening hits
// wraparound, the most negative quotient, each error status but overflow,
// and the reserved op code; random expressions follow, mostly well formed
// with random operands, plus deep stacks, overflow runs, noise and broken
// sequences. Both sides idle in short bursts, and the receiver holds off
// long enough to back the block up. Checking is done by rse_checker.
// ----------------------------------------------------------------------------
module rpn_stack_evaluator_tb;
    import rse_pkg::*;

    localparam logic [OP_W-1:0]  OP_RSVD      = 3'd7;
    localparam logic [NUM_W-1:0] NUM_MAX      = {NUM_W{1'b1}};
    localparam int               TOTAL_ITEMS  = 1950;
    localparam int               TAIL_ITEMS   = 150;
    localparam int               HOLD_CYCLES  = 150;
    localparam int               HOLD_EVERY   = 700;
    localparam int               DRAIN_CYCLES = 64;
    localparam int               STUCK_LIMIT  = 4000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic [OP_W-1:0]            i_op;
    logic [NUM_W-1:0]           i_number;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic [STATUS_W-1:0]        o_status;
    logic signed [DATA_W-1:0]   o_top_value;
    logic                       o_done_res;

    int fail_cnt;
    int pending;
    int beats_in;
    int ok_exprs;
    int err_exprs;

    int sent       = 0;
    bit idle_on    = 1'b1;
    int hold_reqs  = 0;
    int hold_done  = 0;
    int stuck_cnt  = 0;

    rpn_stack_evaluator u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_number    (i_number),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_status    (o_status),
        .o_top_value (o_top_value),
        .o_done_res  (o_done_res)
    );

    rse_checker u_chk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_number    (i_number),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (o_status),
        .i_top_value (o_top_value),
        .i_done_res  (o_done_res),
        .o_fail_cnt  (fail_cnt),
        .o_pending   (pending),
        .o_beats_in  (beats_in),
        .o_ok_exprs  (ok_exprs),
        .o_err_exprs (err_exprs)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // receiver: short stall bursts, plus long hold-offs on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_reqs != hold_done) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_done++;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3) - 1) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            stuck_cnt = 0;
        end else begin
            stuck_cnt++;
        end
        if (stuck_cnt >= STUCK_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, STUCK_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic drive_token(input logic [OP_W-1:0] op, input logic [NUM_W-1:0] num);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_number   <= num;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
    endtask

    function automatic logic [NUM_W-1:0] rand_num();
        case ($urandom_range(0, 9))
            0, 1, 2: return NUM_W'($urandom_range(0, 9));
            3:       return '0;
            4:       return NUM_MAX;
            5:       return NUM_W'(1);
            default: return NUM_W'($urandom);
        endcase
    endfunction

    function automatic logic [OP_W-1:0] rand_arith();
        return OP_W'($urandom_range(int'(OP_DIV), int'(OP_ADD)));
    endfunction

    task automatic eval_expression(input int n_ops, input bit pushes_first);
        int depth;
        int pushes_left;
        depth       = 0;
        pushes_left = n_ops + 1;
        while (pushes_left > 0 || depth > 1) begin
            if (pushes_left > 0 && (depth < 2 || pushes_first || $urandom_range(0, 1))) begin
                drive_token(OP_PUSH, rand_num());
                pushes_left--;
                depth++;
            end else begin
                drive_token(rand_arith(), rand_num());
                depth--;
            end
        end
        drive_token(OP_END, rand_num());
    endtask

    task automatic broken_sequence(input int n);
        repeat (n) begin
            if ($urandom_range(0, 1)) begin
                drive_token(OP_PUSH, rand_num());
            end else begin
                drive_token(rand_arith(), rand_num());
            end
        end
        drive_token(OP_END, rand_num());
    endtask

    task automatic noise_sequence(input int n);
        repeat (n) drive_token(OP_W'($urandom_range(0, 2**OP_W - 1)), NUM_W'($urandom));
        drive_token(OP_END, '0);
    endtask

    task automatic overflow_run();
        repeat (STACK_DEPTH + $urandom_range(0, 2)) drive_token(OP_PUSH, rand_num());
        if ($urandom_range(0, 1)) begin
            drive_token(OP_ADD, '0);
        end
        drive_token(OP_END, '0);
    endtask

    initial begin
        int mode;
        int next_hold;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_op       = OP_PUSH;
        i_number   = '0;
        next_hold  = HOLD_EVERY;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // end on an empty stack
        drive_token(OP_END, '0);
        // divide by zero, then an ignored push
        drive_token(OP_PUSH, NUM_MAX);
        drive_token(OP_PUSH, '0);
        drive_token(OP_DIV, '0);
        drive_token(OP_PUSH, NUM_MAX);
        drive_token(OP_END, '0);
        // wrap to most negative, divide by minus one, multiply wraps
        drive_token(OP_PUSH, NUM_MAX);
        drive_token(OP_PUSH, NUM_W'(1));
        drive_token(OP_ADD, '0);
        drive_token(OP_PUSH, '0);
        drive_token(OP_PUSH, NUM_W'(1));
        drive_token(OP_SUB, '0);
        drive_token(OP_DIV, '0);
        drive_token(OP_PUSH, NUM_W'(3));
        drive_token(OP_MUL, '0);
        drive_token(OP_END, '0);
        // operator with one operand
        drive_token(OP_PUSH, NUM_W'(5));
        drive_token(OP_ADD, '0);
        drive_token(OP_END, '0);
        // invalid and reserved tokens
        drive_token(OP_BAD, NUM_MAX);
        drive_token(OP_END, '0);
        drive_token(OP_RSVD, '0);
        drive_token(OP_END, '0);
        // two values left at end
        drive_token(OP_PUSH, NUM_W'(2));
        drive_token(OP_PUSH, NUM_W'(3));
        drive_token(OP_END, '0);

        while (sent < TOTAL_ITEMS) begin
            idle_on = (sent < TOTAL_ITEMS - TAIL_ITEMS) && ($urandom_range(0, 3) != 0);
            if (sent >= next_hold) begin
                hold_reqs++;
                next_hold += HOLD_EVERY;
            end
            mode = $urandom_range(0, 99);
            if (mode < 60) begin
                eval_expression($urandom_range(1, 6), 1'b0);
            end else if (mode < 70) begin
                eval_expression($urandom_range(7, STACK_DEPTH - 1), $urandom_range(0, 1));
            end else if (mode < 80) begin
                noise_sequence($urandom_range(1, 8));
            end else if (mode < 92) begin
                broken_sequence($urandom_range(1, 8));
            end else begin
                overflow_run();
            end
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Summary: %0d input beats, %0d expressions ended ok, %0d ended with an error",
                 beats_in, ok_exprs, err_exprs);
        $display("         %0d long output hold-offs, %0d mismatches", hold_done, fail_cnt);
        if (fail_cnt == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
